// ===== hdl/sle_pkg.sv =====
`timescale 1ns / 1ps
// sle_pkg: shared types, codes and sizes for the sequential list engine
// used by the interfaces, the controller, the datapath and the top level

package sle_pkg;

  // fixed field widths of the transaction payloads
  localparam int OP_W  = 2;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;

  // default sizes of the list storage
  localparam int DEPTH_DEF  = 64;
  localparam int ELEM_W_DEF = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH,
    ST_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // latch the incoming transaction
    logic check;   // latch the bounds check
    logic issue;   // read one entry and step the address
    logic fin;     // final write and count update
    logic result;  // load the result register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic chk_ok;   // operation may proceed
    logic rd_none;  // nothing to move (insert at the tail)
    logic rd_last;  // current read address is the last one
    logic match;    // locate hit on the entry just read
  } dp_sts_t;

endpackage

// ===== hdl/sle_in_if.sv =====
`timescale 1ns / 1ps
// sle_in_if: input channel of the sequential list engine
// depends on sle_pkg for the payload widths

interface sle_in_if;
  logic                        valid;
  logic                        ready;
  logic [sle_pkg::OP_W-1:0]    op;
  logic [sle_pkg::POS_W-1:0]   position;
  logic [sle_pkg::VAL_W-1:0]   value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

// ===== hdl/sle_out_if.sv =====
`timescale 1ns / 1ps
// sle_out_if: result channel of the sequential list engine
// depends on sle_pkg for the payload widths

interface sle_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [sle_pkg::VAL_W-1:0]   removed_value;
  logic [sle_pkg::POS_W-1:0]   found_position;
  logic [sle_pkg::POS_W-1:0]   count;

  modport source (output valid, output ok, output removed_value, output found_position,
                  output count, input ready);
  modport sink   (input valid, input ok, input removed_value, input found_position,
                  input count, output ready);
endinterface

// ===== hdl/sle_ctrl.sv =====
`timescale 1ns / 1ps
// sle_ctrl: state machine that sequences one list operation at a time
// depends on sle_pkg for the state type and the command/status structs

module sle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sle_pkg::dp_sts_t  sts,
  output sle_pkg::dp_cmd_t  cmd
);

  sle_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // state and result flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sle_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      sle_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sle_pkg::ST_CHECK;
        end
      end
      sle_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        priority if (!sts.chk_ok) begin
          state_nxt = sle_pkg::ST_RESULT;
        end else if (sts.rd_none) begin
          state_nxt = sle_pkg::ST_FINISH;
        end else begin
          state_nxt = sle_pkg::ST_RUN;
        end
      end
      sle_pkg::ST_RUN: begin
        // stop the scan on the first hit
        priority if (sts.match) begin
          state_nxt = sle_pkg::ST_FINISH;
        end else begin
          cmd.issue = 1'b1;
          if (sts.rd_last) begin
            state_nxt = sle_pkg::ST_DRAIN;
          end
        end
      end
      sle_pkg::ST_DRAIN: begin
        state_nxt = sle_pkg::ST_FINISH;
      end
      sle_pkg::ST_FINISH: begin
        cmd.fin   = 1'b1;
        state_nxt = sle_pkg::ST_RESULT;
      end
      sle_pkg::ST_RESULT: begin
        if (slot_free) begin
          cmd.result = 1'b1;
          state_nxt  = sle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sle_pkg::ST_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.result) begin
      out_valid_nxt = 1'b1;
    end
  end

  // a result load always leaves a pending transaction and an idle controller
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |=> out_valid_r && state_r == sle_pkg::ST_IDLE)
    else $error("result load did not settle");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.result)
    else $error("result overwritten while pending");

  // reads are issued only while an operation walks the list
  a_issue_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> $past(state_r) == sle_pkg::ST_CHECK || $past(state_r) == sle_pkg::ST_RUN)
    else $error("read issued outside a scan");

endmodule

// ===== hdl/sle_datapath.sv =====
`timescale 1ns / 1ps
// sle_datapath: list memory, count, address walker and result register
// depends on sle_pkg for widths, operation codes and the command/status structs

module sle_datapath #(
  parameter int DEPTH      = sle_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = sle_pkg::ELEM_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sle_pkg::OP_W-1:0]    in_op,
  input  logic [sle_pkg::POS_W-1:0]   in_position,
  input  logic [sle_pkg::VAL_W-1:0]   in_value,
  input  sle_pkg::dp_cmd_t            cmd,
  output sle_pkg::dp_sts_t            sts,
  output logic                        out_ok,
  output logic [sle_pkg::VAL_W-1:0]   out_removed_value,
  output logic [sle_pkg::POS_W-1:0]   out_found_position,
  output logic [sle_pkg::POS_W-1:0]   out_count
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

  // list storage
  logic [ELEM_WIDTH-1:0] mem [DEPTH];

  logic [sle_pkg::OP_W-1:0]  op_r;
  logic [sle_pkg::POS_W-1:0] pos_r;
  logic [ELEM_WIDTH-1:0]     key_r;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic                      s1_valid_r;
  logic [AW-1:0]             s1_addr_r;
  logic [ELEM_WIDTH-1:0]     rdata_r;
  logic [ELEM_WIDTH-1:0]     removed_r;
  logic [CW-1:0]             found_r;
  logic                      chk_r;

  logic            is_ins, is_del, is_loc;
  logic [CMPW-1:0] pos_w, cnt_w, pos_m1;
  logic [AW-1:0]   pos_addr, last_addr;
  logic            ins_ok, del_ok, loc_ok;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic            take_removed;

  assign is_ins = (op_r == sle_pkg::OP_INSERT);
  assign is_del = (op_r == sle_pkg::OP_DELETE);
  assign is_loc = (op_r == sle_pkg::OP_LOCATE);

  // bounds checks on the latched transaction
  assign pos_w     = CMPW'(pos_r);
  assign cnt_w     = CMPW'(cnt_r);
  assign pos_m1    = pos_w - CMPW'(1);
  assign pos_addr  = AW'(pos_m1);
  assign last_addr = AW'(cnt_w - CMPW'(1));
  assign ins_ok    = (pos_w != '0) && (pos_w <= cnt_w + CMPW'(1)) && (cnt_w < CMPW'(DEPTH));
  assign del_ok    = (pos_w != '0) && (pos_w <= cnt_w);
  assign loc_ok    = (cnt_w != '0);

  always_comb begin
    sts.chk_ok  = (is_ins && ins_ok) || (is_del && del_ok) || (is_loc && loc_ok);
    sts.rd_none = is_ins && (pos_m1 == cnt_w);
    sts.rd_last = is_ins ? (addr_r == pos_addr) : (addr_r == last_addr);
    sts.match   = s1_valid_r && is_loc && (rdata_r == key_r) && (found_r == '0);
  end

  // transaction latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      pos_r <= in_position;
      key_r <= ELEM_WIDTH'(in_value);
    end
    if (cmd.check) begin
      chk_r <= sts.chk_ok;
    end
  end

  // address walker: descending for insert, ascending otherwise
  always_comb begin
    addr_nxt = addr_r;
    priority if (cmd.load) begin
      priority if (in_op == sle_pkg::OP_INSERT) begin
        addr_nxt = AW'(CMPW'(cnt_r) - CMPW'(1));
      end else if (in_op == sle_pkg::OP_DELETE) begin
        addr_nxt = AW'(CMPW'(in_position) - CMPW'(1));
      end else begin
        addr_nxt = '0;
      end
    end else if (cmd.issue) begin
      addr_nxt = is_ins ? (addr_r - AW'(1)) : (addr_r + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  // memory read port with registered data
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rdata_r <= mem[addr_r];
    end
    s1_addr_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue;
    end
  end

  // write port: shift from the read stage or store the inserted element
  assign take_removed = s1_valid_r && is_del && (s1_addr_r == pos_addr);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr_r;
    mem_wdata = rdata_r;
    priority if (cmd.fin && is_ins) begin
      mem_we    = 1'b1;
      mem_waddr = pos_addr;
      mem_wdata = key_r;
    end else if (s1_valid_r && is_ins) begin
      mem_we    = 1'b1;
      mem_waddr = s1_addr_r + AW'(1);
    end else if (s1_valid_r && is_del && !take_removed) begin
      mem_we    = 1'b1;
      mem_waddr = s1_addr_r - AW'(1);
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // removed element and first match
  always_ff @(posedge clk) begin
    if (take_removed) begin
      removed_r <= rdata_r;
    end
    if (cmd.load) begin
      found_r <= '0;
    end else if (sts.match) begin
      found_r <= CW'(CMPW'(s1_addr_r) + CMPW'(1));
    end
  end

  // element count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.fin) begin
      priority if (is_ins) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (is_del) begin
        cnt_nxt = cnt_r - CW'(1);
      end else begin
        cnt_nxt = cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_ok             <= is_loc ? (found_r != '0) : ((is_ins || is_del) && chk_r);
      out_removed_value  <= (is_del && chk_r) ? sle_pkg::VAL_W'(removed_r) : '0;
      out_found_position <= is_loc ? sle_pkg::POS_W'(found_r) : '0;
      out_count          <= sle_pkg::POS_W'(cnt_r);
    end
  end

  // the count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(cnt_r) <= CMPW'(DEPTH))
    else $error("element count above capacity");

  // the final insert write never meets a shift write
  a_wr_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && !is_loc) |-> !s1_valid_r)
    else $error("write port collision");

  // a new transaction clears the match position
  a_found_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> found_r == '0)
    else $error("stale match position");

endmodule

// ===== hdl/sequential_list_engine.sv =====
`timescale 1ns / 1ps
// Ordered list of up to DEPTH elements held in a single-port-write, single-read RAM.
// Each input transaction is one insert, delete or locate and gives one result
// transaction. After a transaction is accepted the operation walks n entries,
// where n is count - position + 1 for insert and delete and the match position
// (or count when nothing matches) for locate. An insert at the tail walks nothing;
// a rejected operation (bad position, full list, locate on an empty list, unused
// op code) walks nothing and goes from the bounds check straight to the result.
// The result waits until the previous one has been taken from the output register.
// The walk reads one entry per cycle and, for insert and delete, writes each moved
// entry one place up or down in the next cycle, so the RAM read port sets the pace.
// One operation is in flight at a time; a new transaction is taken while the
// previous result still waits in the output register. No clearing pass is needed
// after reset.
// depends on sle_pkg, sle_in_if, sle_out_if, sle_ctrl and sle_datapath

module sequential_list_engine #(
  parameter int DEPTH      = sle_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = sle_pkg::ELEM_W_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  sle_in_if.sink   in_ch,
  sle_out_if.source out_ch
);

  sle_pkg::dp_cmd_t cmd;
  sle_pkg::dp_sts_t sts;

  // controller
  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  sle_datapath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_op              (in_ch.op),
    .in_position        (in_ch.position),
    .in_value           (in_ch.value),
    .cmd                (cmd),
    .sts                (sts),
    .out_ok             (out_ch.ok),
    .out_removed_value  (out_ch.removed_value),
    .out_found_position (out_ch.found_position),
    .out_count          (out_ch.count)
  );

endmodule
